// ===== sv/s256bc_pkg.sv =====
// Shared types, round constants and round functions for the SHA-256 block compressor.
// Used by the word collector, the block queue and the round engine.
// No dependencies.
`default_nettype none

package s256bc_pkg;

	localparam int WordW   = 32;
	localparam int BlkWords = 16;
	localparam int Rounds  = 64;
	localparam int DigWords = 8;

	// Element 0 holds the first word of the block.
	typedef logic [BlkWords-1:0][WordW-1:0] block_t;

	typedef struct packed {
		logic   valid;
		block_t data;
	} blk_push_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	localparam logic [WordW-1:0] ROUND_K [Rounds] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [WordW-1:0] INIT_HASH [DigWords] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	function automatic logic [WordW-1:0] big_sigma0(input logic [WordW-1:0] x);
		return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
	endfunction

	function automatic logic [WordW-1:0] big_sigma1(input logic [WordW-1:0] x);
		return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
	endfunction

	function automatic logic [WordW-1:0] small_sigma0(input logic [WordW-1:0] x);
		return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
	endfunction

	function automatic logic [WordW-1:0] small_sigma1(input logic [WordW-1:0] x);
		return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
	endfunction

	function automatic logic [WordW-1:0] ch_f(input logic [WordW-1:0] e,
			input logic [WordW-1:0] f, input logic [WordW-1:0] g);
		return (e & f) ^ (~e & g);
	endfunction

	function automatic logic [WordW-1:0] maj_f(input logic [WordW-1:0] a,
			input logic [WordW-1:0] b, input logic [WordW-1:0] c);
		return (a & b) | (c & (a | b));
	endfunction

endpackage

`default_nettype wire

// ===== sv/s256bc_front.sv =====
// Word collector: gathers sixteen message words and pushes the complete block.
// Depends on s256bc_pkg.
`default_nettype none

module s256bc_front import s256bc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [WordW-1:0] message_word,
	input  q_status_t             q_stat,
	output logic                  busy,
	output blk_push_t             push
);

	logic [3:0]       word_cnt_q;
	logic [WordW-1:0] buf_q [BlkWords-1];
	logic             accept;
	logic             last_in_blk;

	assign last_in_blk = (word_cnt_q == 4'(BlkWords - 1));
	// Only the closing word of a block needs room in the queue.
	assign busy   = last_in_blk && q_stat.full;
	assign accept = start && !busy;

	always_comb begin
		push.valid = accept && last_in_blk;
		for (int i = 0; i < BlkWords - 1; i++) begin
			push.data[i] = buf_q[i];
		end
		push.data[BlkWords-1] = message_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_cnt_q <= '0;
		end else if (accept) begin
			word_cnt_q <= word_cnt_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !last_in_blk) begin
			buf_q[word_cnt_q] <= message_word;
		end
	end

endmodule

`default_nettype wire

// ===== sv/s256bc_fifo.sv =====
// Two-entry block queue between the word collector and the round engine.
// Depends on s256bc_pkg.
`default_nettype none

module s256bc_fifo import s256bc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  blk_push_t push,
	input  wire logic pop,
	output block_t    head,
	output q_status_t q_stat
);

	block_t     mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (cnt_q == 2'd2);
	assign q_stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			unique case ({push.valid, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push.valid |-> (!q_stat.full || pop))
		else $error("block pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("block popped from an empty queue");

endmodule

`default_nettype wire

// ===== sv/s256bc_core.sv =====
// Round engine: runs the 64 rounds on a queued block, one round a cycle,
// then adds the initial hash and shifts the eight digest words out.
// Depends on s256bc_pkg.
`default_nettype none

module s256bc_core import s256bc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  q_status_t             q_stat,
	input  block_t                head,
	output logic                  pop,
	output logic                  strobe,
	output logic [WordW-1:0]      digest_word,
	output logic                  last_word
);

	typedef enum logic [2:0] {
		S_IDLE  = 3'b001,
		S_ROUND = 3'b010,
		S_FINAL = 3'b100
	} state_t;

	state_t           state_q;
	logic [5:0]       round_q;
	block_t           w_q;
	logic [WordW-1:0] v_q   [DigWords];
	logic [WordW-1:0] out_q [DigWords];
	logic [3:0]       out_cnt_q;

	logic             out_free;
	logic             load_out;
	logic [WordW-1:0] t1, t2, w_next;

	// The bank may be reloaded on the cycle its final word goes out.
	assign out_free = (out_cnt_q <= 4'd1);
	assign load_out = (state_q == S_FINAL) && out_free;
	assign pop      = !q_stat.empty && ((state_q == S_IDLE) || load_out);

	assign t1 = v_q[7] + big_sigma1(v_q[4]) + ch_f(v_q[4], v_q[5], v_q[6])
		+ ROUND_K[round_q] + w_q[0];
	assign t2 = big_sigma0(v_q[0]) + maj_f(v_q[0], v_q[1], v_q[2]);
	// The window holds w[i] .. w[i+15]; the new tail word is w[i+16].
	assign w_next = small_sigma1(w_q[14]) + w_q[9] + small_sigma0(w_q[1]) + w_q[0];

	assign strobe      = (out_cnt_q != 4'd0);
	assign digest_word = out_q[0];
	assign last_word   = (out_cnt_q == 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			round_q   <= '0;
			out_cnt_q <= '0;
		end else begin
			if (load_out) begin
				out_cnt_q <= 4'(DigWords);
			end else if (strobe) begin
				out_cnt_q <= out_cnt_q - 4'd1;
			end
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						state_q <= S_ROUND;
						round_q <= '0;
					end
				end
				S_ROUND: begin
					round_q <= round_q + 6'd1;
					if (round_q == 6'(Rounds - 1)) begin
						state_q <= S_FINAL;
					end
				end
				S_FINAL: begin
					if (pop) begin
						state_q <= S_ROUND;
						round_q <= '0;
					end else if (load_out) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			w_q <= head;
			for (int i = 0; i < DigWords; i++) begin
				v_q[i] <= INIT_HASH[i];
			end
		end else if (state_q == S_ROUND) begin
			w_q    <= {w_next, w_q[BlkWords-1:1]};
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
		if (load_out) begin
			for (int i = 0; i < DigWords; i++) begin
				out_q[i] <= INIT_HASH[i] + v_q[i];
			end
		end else begin
			for (int i = 0; i < DigWords - 1; i++) begin
				out_q[i] <= out_q[i+1];
			end
		end
	end

	a_round_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND && round_q == 6'(Rounds - 1)) |=> (state_q == S_FINAL))
		else $error("round engine did not finish after the last round");

	a_bank_load: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |=> (out_cnt_q == 4'(DigWords)) && strobe)
		else $error("digest bank not loaded with eight words");

	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_cnt_q <= 4'(DigWords)) && (!last_word || strobe))
		else $error("digest word count out of range");

endmodule

`default_nettype wire

// ===== sv/sha256_block_compress.sv =====
// SHA-256 single-block compressor: sixteen words in, eight digest words out.
// A completed block goes through the queue into the round engine, runs its rounds and the final add,
// and the digest is then shown from H0 through H7, with last_word on H7.
// The engine takes a queued block in the same step as the final add of the block before;
// words are taken one a cycle while the two-block queue has room.
// Reset clears the word count, queue and engine; no digest word is shown until a block ends.
// Depends on s256bc_pkg, s256bc_front, s256bc_fifo and s256bc_core.
`default_nettype none

module sha256_block_compress import s256bc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire logic [WordW-1:0] message_word,
	output logic                  strobe,
	output logic [WordW-1:0]      digest_word,
	output logic                  last_word
);

	blk_push_t push;
	q_status_t q_stat;
	block_t    head;
	logic      pop;

	s256bc_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.message_word (message_word),
		.q_stat       (q_stat),
		.busy         (busy),
		.push         (push)
	);

	s256bc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.head   (head),
		.q_stat (q_stat)
	);

	s256bc_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head        (head),
		.pop         (pop),
		.strobe      (strobe),
		.digest_word (digest_word),
		.last_word   (last_word)
	);

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for sha256_block_compress: feeds message blocks word by word and checks every
// digest word against a SHA-256 compression model kept inside this file.
// Depends on s256bc_pkg for the word width and on the RTL of the block.
module tb;
	import s256bc_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int MAX_SHOWN   = 10;

	localparam logic [31:0] SHA_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] SHA_IV [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	typedef struct packed {
		logic [WordW-1:0] word;
		logic             last;
	} digest_entry_t;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	logic [WordW-1:0] message_word;
	logic             strobe;
	logic [WordW-1:0] digest_word;
	logic             last_word;

	digest_entry_t    pending_digests [$];
	digest_entry_t    next_digest;
	logic [31:0]      block_words [16];
	int               word_index;
	int               words_sent;
	int               blocks_sent;
	int               digests_checked;
	int               fail_count;
	int               stall_cycles;
	int               burst_left;
	bit               gaps_on;

	sha256_block_compress u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.message_word (message_word),
		.strobe       (strobe),
		.digest_word  (digest_word),
		.last_word    (last_word)
	);

	always #5 clk = ~clk;

	function automatic logic [31:0] ror(input logic [31:0] x, input int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// Runs the 64 rounds on the collected block from the initial value and queues
	// the eight digest words that the block should emit.
	task automatic sha256_expect_block();
		logic [31:0]   w [16];
		logic [31:0]   v [8];
		logic [31:0]   wt, s0, s1, t1, t2;
		digest_entry_t d;
		int            i;
		for (i = 0; i < 16; i++)
			w[i] = block_words[i];
		for (i = 0; i < 8; i++)
			v[i] = SHA_IV[i];
		for (i = 0; i < 64; i++) begin
			if (i < 16) begin
				wt = w[i];
			end else begin
				s1 = ror(w[(i - 2) % 16], 17) ^ ror(w[(i - 2) % 16], 19) ^ (w[(i - 2) % 16] >> 10);
				s0 = ror(w[(i - 15) % 16], 7) ^ ror(w[(i - 15) % 16], 18) ^ (w[(i - 15) % 16] >> 3);
				wt = s1 + w[(i - 7) % 16] + s0 + w[i % 16];
				w[i % 16] = wt;
			end
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + SHA_K[i] + wt;
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) | (v[2] & (v[0] | v[1])));
			v[7] = v[6];
			v[6] = v[5];
			v[5] = v[4];
			v[4] = v[3] + t1;
			v[3] = v[2];
			v[2] = v[1];
			v[1] = v[0];
			v[0] = t1 + t2;
		end
		for (i = 0; i < 8; i++) begin
			d.word = SHA_IV[i] + v[i];
			d.last = (i == 7);
			pending_digests.push_back(d);
		end
	endtask

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= MAX_SHOWN)
			$display("%0t: %s", $time, msg);
	endtask

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			start        <= 1'b0;
			message_word <= $urandom;
		end
	endtask

	// Sends one word and waits for the edge that takes it.
	task automatic send_word(input logic [31:0] w);
		if (gaps_on && burst_left == 0) begin
			idle_cycles($urandom_range(0, 12));
			burst_left = $urandom_range(1, 20);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		start        <= 1'b1;
		message_word <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		words_sent++;
		block_words[word_index] = w;
		if (word_index == 15) begin
			word_index = 0;
			blocks_sent++;
			sha256_expect_block();
		end else begin
			word_index++;
		end
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 9))
			0:       return 32'h0000_0000;
			1:       return 32'hffff_ffff;
			2:       return 32'h1 << $urandom_range(0, 31);
			default: return $urandom;
		endcase
	endfunction

	task automatic send_random_block();
		repeat (16)
			send_word(pick_word());
	endtask

	// The sender goes quiet first, so no word is taken while the results drain.
	task automatic wait_digests_drained();
		@(negedge clk);
		start <= 1'b0;
		while (pending_digests.size() != 0)
			@(posedge clk);
	endtask

	// One block built from the extremes of the word, single set or cleared bits, alternating bits and counting nibbles.
	task automatic test_extreme_block();
		logic [31:0] pattern [16];
		int          i;
		pattern = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
			32'h7fff_ffff, 32'hffff_fffe, 32'h5555_5555, 32'haaaa_aaaa,
			32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 32'hffff_ffff,
			32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, 32'h7654_3210};
		gaps_on = 1'b0;
		for (i = 0; i < 16; i++)
			send_word(pattern[i]);
	endtask

	// Waits for the engine to go quiet before the next block, so the word count
	// wrap and a restart from idle are both seen.
	task automatic test_drain_and_restart();
		gaps_on = 1'b0;
		send_random_block();
		wait_digests_drained();
		idle_cycles($urandom_range(1, 10));
		send_random_block();
	endtask

	// Bursty traffic with some blocks sent back to back, which fills the block queue.
	task automatic test_random_blocks();
		int b;
		for (b = 0; b < 8; b++) begin
			gaps_on    = (b % 3 != 0);
			burst_left = 0;
			send_random_block();
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && strobe === 1'b1) begin
			if (pending_digests.size() == 0) begin
				note_failure($sformatf("digest word %h last %b with none expected",
					digest_word, last_word));
			end else begin
				next_digest = pending_digests.pop_front();
				digests_checked++;
				if (digest_word !== next_digest.word || last_word !== next_digest.last)
					note_failure($sformatf("digest word %h last %b, expected %h last %b",
						digest_word, last_word, next_digest.word, next_digest.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || strobe === 1'b1)
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, stall_cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		clk             = 1'b0;
		arst_n          = 1'b0;
		start           = 1'b0;
		message_word    = '0;
		word_index      = 0;
		words_sent      = 0;
		blocks_sent     = 0;
		digests_checked = 0;
		fail_count      = 0;
		stall_cycles    = 0;
		burst_left      = 0;
		gaps_on         = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_extreme_block();
		test_drain_and_restart();
		test_random_blocks();

		@(negedge clk);
		start <= 1'b0;
		wait_digests_drained();
		repeat (100) @(posedge clk);
		if (pending_digests.size() != 0)
			note_failure($sformatf("%0d digest words never arrived", pending_digests.size()));

		$display("Sent %0d message words in %0d blocks and checked %0d digest words,",
			words_sent, blocks_sent, digests_checked);
		$display("covering an extremes block, a drained restart and bursty random blocks.");
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
sv/s256bc_pkg.sv
sv/s256bc_front.sv
sv/s256bc_fifo.sv
sv/s256bc_core.sv
sv/sha256_block_compress.sv
sim/tb.sv
